// ===== src/fir_pkg.sv =====
// Shared types for the direct-form FIR filter.
package fir_pkg;

  localparam int unsigned ActionWidth = 2;
  localparam int unsigned IndexWidth  = 6;
  localparam int unsigned TapCntWidth = 7;

  typedef enum logic [ActionWidth-1:0] {
    ACT_FILTER = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_FEED,
    S_SUM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== src/fir_cell.sv =====
// One tap of the FIR chain: delayed sample, coefficient, product and partial sum.
module fir_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned SW    = 16,
  parameter int unsigned CW    = 16,
  parameter int unsigned ACC_W = 38
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fir_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [fir_pkg::IndexWidth-1:0]      coeff_index_i,
  input  logic signed [CW-1:0]                coeff_value_i,
  input  logic [fir_pkg::TapCntWidth-1:0]     tap_count_i,
  input  logic signed [SW-1:0]                x_i,
  output logic signed [SW-1:0]                x_o,
  input  logic                                tok_i,
  input  logic signed [ACC_W-1:0]             psum_i,
  output logic                                tok_o,
  output logic signed [ACC_W-1:0]             psum_o
);

  logic signed [SW-1:0]    x_q;
  logic signed [CW-1:0]    c_q;
  logic signed [SW+CW-1:0] prod_q;
  logic signed [ACC_W-1:0] psum_q;
  logic                    tok_q;
  logic                    active;
  logic                    sel;
  logic signed [ACC_W-1:0] addend;

  // tap 0 always counts, even for a tap count of zero
  assign active = (IDX == 0) || (32'(IDX) < 32'(tap_count_i));
  assign sel    = (32'(IDX) == 32'(coeff_index_i));
  assign addend = active ? ACC_W'(prod_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      c_q   <= '0;
      tok_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        x_q <= '0;
      end else if (ctrl_i.shift) begin
        x_q <= x_i;
      end
      if (ctrl_i.load && sel) begin
        c_q <= coeff_value_i;
      end
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= x_q * c_q;
    if (tok_i) begin
      psum_q <= psum_i + addend;
    end
  end

  assign x_o    = x_q;
  assign tok_o  = tok_q;
  assign psum_o = psum_q;

endmodule

// ===== src/fir_filter_direct_form.sv =====
// Top level of the direct-form FIR filter: tap chain, sequencer and output stage.
//
//  channel  direction  handshake                   payload
//  in       input      in_valid_i / in_stall_o     action_i, sample_in_i, coeff_index_i,
//                                                  coeff_value_i
//  out      output     out_valid_o / out_stall_i   sample_out_o, saturated_o
//  cfg      input      cfg_valid_i / cfg_ready_o   cfg_tap_count_i
//
// A filter request passes through S_PROD, S_FEED, S_SUM and S_DONE; the partial
// sum walks the tap chain one cell per cycle. Load and clear requests act on acceptance.
// The next request is accepted once the sequencer is back in idle; a held result
// only holds the next filter request at its last step, until the output frees up.
// Reset clears the delay line and coefficients and sets tap_count to 64.
module fir_filter_direct_form #(
  parameter int unsigned MAX_TAPS     = 64,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEFF_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fir_pkg::ActionWidth-1:0]     action_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic [fir_pkg::IndexWidth-1:0]      coeff_index_i,
  input  logic signed [COEFF_WIDTH-1:0]       coeff_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o,
  output logic                                saturated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fir_pkg::TapCntWidth-1:0]     cfg_tap_count_i
);

  localparam int unsigned FULL_W = SAMPLE_WIDTH + COEFF_WIDTH + $clog2(MAX_TAPS);
  localparam int unsigned ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
  localparam int unsigned YW     = ACC_W - COEFF_WIDTH + 1;
  localparam int unsigned HW     = YW - SAMPLE_WIDTH + 1;

  fir_pkg::state_e    state_q, state_d;
  fir_pkg::action_e   action;
  fir_pkg::cell_ctrl_t ctrl;
  logic [fir_pkg::TapCntWidth-1:0] tap_count_q;
  logic                in_take;
  logic                feed;
  logic                out_load;
  logic                out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q, sample_out_d;
  logic                saturated_q, saturated_d;

  logic signed [SAMPLE_WIDTH-1:0] x_chain [MAX_TAPS+1];
  logic signed [ACC_W-1:0]        p_chain [MAX_TAPS+1];
  logic [MAX_TAPS:0]              t_chain;

  logic signed [ACC_W-1:0] rounded;
  logic [YW-1:0]           y;
  logic [HW-1:0]           y_hi;
  logic                    in_range;

  assign action  = fir_pkg::action_e'(action_i);
  assign in_take = in_valid_i && !in_stall_o;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tap_count_q <= cfg_tap_count_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      fir_pkg::S_IDLE: begin
        if (in_take && action == fir_pkg::ACT_FILTER) state_d = fir_pkg::S_PROD;
      end
      fir_pkg::S_PROD: state_d = fir_pkg::S_FEED;
      fir_pkg::S_FEED: state_d = fir_pkg::S_SUM;
      fir_pkg::S_SUM: begin
        if (t_chain[MAX_TAPS]) state_d = fir_pkg::S_DONE;
      end
      fir_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = fir_pkg::S_IDLE;
      end
      default: state_d = fir_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ctrl       = '0;
    feed       = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      fir_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        ctrl.shift = in_take && (action == fir_pkg::ACT_FILTER);
        ctrl.load  = in_take && (action == fir_pkg::ACT_LOAD);
        ctrl.clear = in_take && (action == fir_pkg::ACT_CLEAR);
      end
      fir_pkg::S_FEED: feed = 1'b1;
      fir_pkg::S_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fir_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // tap chain
  assign x_chain[0] = sample_in_i;
  assign p_chain[0] = '0;
  assign t_chain[0] = feed;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    fir_cell #(
      .IDX  (k),
      .SW   (SAMPLE_WIDTH),
      .CW   (COEFF_WIDTH),
      .ACC_W(ACC_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .coeff_index_i(coeff_index_i),
      .coeff_value_i(coeff_value_i),
      .tap_count_i  (tap_count_q),
      .x_i          (x_chain[k]),
      .x_o          (x_chain[k+1]),
      .tok_i        (t_chain[k]),
      .psum_i       (p_chain[k]),
      .tok_o        (t_chain[k+1]),
      .psum_o       (p_chain[k+1])
    );
  end

  // round half up, shift, saturate
  assign rounded  = p_chain[MAX_TAPS]
                  + {{(ACC_W-COEFF_WIDTH+1){1'b0}}, 1'b1, {(COEFF_WIDTH-2){1'b0}}};
  assign y        = rounded[ACC_W-1:COEFF_WIDTH-1];
  assign y_hi     = y[YW-1:SAMPLE_WIDTH-1];
  assign in_range = (y_hi == '0) || (y_hi == '1);

  always_comb begin
    if (in_range) begin
      sample_out_d = y[SAMPLE_WIDTH-1:0];
      saturated_d  = 1'b0;
    end else if (y[YW-1]) begin
      sample_out_d = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      saturated_d  = 1'b1;
    end else begin
      sample_out_d = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      saturated_d  = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_out_q <= sample_out_d;
      saturated_q  <= saturated_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign saturated_o  = saturated_q;

`ifndef SYNTHESIS
  a_tok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(t_chain))
    else $error("more than one partial sum in the tap chain");

  a_tok_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fir_pkg::S_IDLE) |-> (t_chain == '0))
    else $error("partial sum in flight while idle");

  a_tok_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_chain[MAX_TAPS] |-> (state_q == fir_pkg::S_SUM))
    else $error("chain finished outside the sum phase");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites a held output");
`endif

endmodule
